// ----- sv/tsg_pkg.sv -----
// Shared constants and types for the two-stage gap hysteresis material.
// No dependencies.
package tsg_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	localparam logic [1:0] FUNC_SET    = 2'd0;
	localparam logic [1:0] FUNC_COMMIT = 2'd1;
	localparam logic [1:0] FUNC_REVERT = 2'd2;
	localparam logic [1:0] FUNC_START  = 2'd3;

	localparam logic [1:0] STATUS_OK  = 2'd0;
	localparam logic [1:0] STATUS_GAP = 2'd1;
	localparam logic [1:0] STATUS_SAT = 2'd2;

	localparam logic [2:0] REG_FY1 = 3'd0;
	localparam logic [2:0] REG_K1  = 3'd1;
	localparam logic [2:0] REG_KP1 = 3'd2;
	localparam logic [2:0] REG_FY2 = 3'd3;
	localparam logic [2:0] REG_K2  = 3'd4;
	localparam logic [2:0] REG_KP2 = 3'd5;
	localparam logic [2:0] REG_GAP = 3'd6;

	// muldiv modes: a*b/scale, a*scale/c, a*b/c
	localparam logic [1:0] MD_MUL = 2'd0;
	localparam logic [1:0] MD_DIV = 2'd1;
	localparam logic [1:0] MD_GEN = 2'd2;

	typedef struct packed {
		logic       start;
		logic [1:0] mode;
	} md_ctl_t;

endpackage

// ----- sv/tsg_if.sv -----
// Valid/ready channel interfaces for command and result transactions.
// Depends on nothing.
interface tsg_in_if #(parameter int DATA_WIDTH = 32);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   func;
	logic signed [DATA_WIDTH-1:0] strain;
	modport source (output valid, func, strain, input ready);
	modport sink (input valid, func, strain, output ready);
endinterface

interface tsg_out_if #(parameter int DATA_WIDTH = 32);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] stress;
	logic signed [DATA_WIDTH-1:0] tangent;
	logic [1:0]                   status;
	modport source (output valid, stress, tangent, status, input ready);
	modport sink (input valid, stress, tangent, status, output ready);
endinterface

// ----- sv/tsg_md.sv -----
// Shared mul-div unit (a*b/scale, a*scale/c, a*b/c), truncated toward zero,
// saturated. Restoring division one quotient bit per cycle. Uses tsg_pkg.
module tsg_md #(
	parameter int DATA_WIDTH = tsg_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = tsg_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tsg_pkg::md_ctl_t             ctl,
	input  logic signed [DATA_WIDTH-1:0] a,
	input  logic signed [DATA_WIDTH-1:0] b,
	input  logic signed [DATA_WIDTH-1:0] c,
	output logic signed [DATA_WIDTH-1:0] res,
	output logic                         sat,
	output logic                         done
);
	localparam int W  = DATA_WIDTH;
	localparam int PW = 2 * DATA_WIDTH + FRAC_BITS;
	localparam int CW = $clog2(PW + 1);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_DEC  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [PW-1:0] LIM_POS = PW'({1'b0, {(W-1){1'b1}}});
	localparam logic [PW-1:0] LIM_NEG = PW'({1'b1, {(W-1){1'b0}}});

	logic [2:0]    state_q;
	logic [1:0]    mode_q;
	logic [W-1:0]  ma_q, mb_q, mc_q;
	logic          neg_q, ovf_q;
	logic [PW-1:0] p_q;
	logic [W-1:0]  rem_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    rem_sh;
	logic          take;
	logic [PW-1:0] lim;

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	assign rem_sh = {rem_q, p_q[PW-1]};
	assign take   = rem_sh >= {1'b0, mc_q};
	assign lim    = neg_q ? LIM_NEG : LIM_POS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctl.start) begin
						mode_q  <= ctl.mode;
						ma_q    <= mag(a);
						mb_q    <= (ctl.mode == tsg_pkg::MD_DIV) ? '0 : mag(b);
						mc_q    <= (ctl.mode == tsg_pkg::MD_MUL) ? '0 : mag(c);
						neg_q   <= a[W-1] ^ ((ctl.mode != tsg_pkg::MD_DIV) & b[W-1])
							^ ((ctl.mode != tsg_pkg::MD_MUL) & c[W-1]);
						ovf_q   <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mode_q == tsg_pkg::MD_DIV)
						p_q <= PW'(ma_q) << FRAC_BITS;
					else
						p_q <= PW'(ma_q * mb_q);
					state_q <= S_DEC;
				end
				S_DEC: begin
					rem_q <= '0;
					cnt_q <= CW'(PW);
					if (mode_q == tsg_pkg::MD_MUL) begin
						p_q     <= p_q >> FRAC_BITS;
						state_q <= S_FIN;
					end else if (mc_q == '0) begin
						ovf_q   <= (p_q != '0);
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q   <= take ? W'(rem_sh - {1'b0, mc_q}) : rem_sh[W-1:0];
					p_q     <= {p_q[PW-2:0], take};
					cnt_q   <= cnt_q - 1'b1;
					if (cnt_q == CW'(1))
						state_q <= S_FIN;
				end
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a zero divisor with a nonzero product leaves p_q nonzero; saturate on ovf_q
	always_comb begin
		done = (state_q == S_FIN);
		sat  = ovf_q || (p_q > lim);
		if (sat)
			res = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		else if (ovf_q == 1'b0 && mc_q == '0 && mode_q != tsg_pkg::MD_MUL)
			res = '0;
		else
			res = neg_q ? W'(-p_q[W-1:0]) : p_q[W-1:0];
	end

endmodule

// ----- sv/two_stage_gap_hysteresis_material.sv -----
// Two-stage gap hysteresis material, top level: command sequencer and state.
// Uses tsg_pkg, tsg_in_if, tsg_out_if and the shared unit tsg_md.
//
// Channels: in_ch carries a command (func) and a trial strain; out_ch returns
// one result per command: trial stress, secant tangent and status.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
// written only while idle by the user, as the block does not enforce it;
// unknown indexes are ignored. Commit, revert and revert-to-start go straight
// from idle to the output register. A set-strain command runs a sequence on
// one shared multiply-divide unit: up to two springs of three multiplies and
// one divide each, a split and the secant divide for a nonzero step; a zero
// step skips the sequence, and a gap outside range ends it at the gap check.
// in_ch.ready is high only while the sequencer is idle; one command at a time.
// The result sits in an output register; a stalled receiver holds it and the
// next command is still accepted, finishing only once that register frees.
// Reset clears all committed and trial state to zero, both slopes to 1.0,
// and the registers to their defaults.
module two_stage_gap_hysteresis_material #(
	parameter int DATA_WIDTH = tsg_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = tsg_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [DATA_WIDTH-1:0] cfg_data,
	tsg_in_if.sink                in_ch,
	tsg_out_if.source             out_ch
);
	localparam int W = DATA_WIDTH;
	localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ONE_SAT = (FRAC_BITS >= W - 1) ? MAXV
		: ({{(W-1){1'b0}}, 1'b1} << FRAC_BITS);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MDK   = 4'd1;
	localparam logic [3:0] ST_BASE  = 4'd2;
	localparam logic [3:0] ST_RATIO = 4'd3;
	localparam logic [3:0] ST_OFF   = 4'd4;
	localparam logic [3:0] ST_CLIP  = 4'd5;
	localparam logic [3:0] ST_GAP   = 4'd6;
	localparam logic [3:0] ST_POST  = 4'd7;
	localparam logic [3:0] ST_SPLIT = 4'd8;
	localparam logic [3:0] ST_SUM   = 4'd9;
	localparam logic [3:0] ST_SLOPE = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;

	typedef struct packed {
		logic                f;
		logic signed [W-1:0] v;
	} sv_t;

	function automatic sv_t f_add(input logic signed [W-1:0] x, input logic signed [W-1:0] y);
		logic [W:0] s;
		sv_t        r;
		s   = {x[W-1], x} + {y[W-1], y};
		r.f = s[W] ^ s[W-1];
		r.v = r.f ? (s[W] ? MINV : MAXV) : s[W-1:0];
		return r;
	endfunction

	function automatic sv_t f_sub(input logic signed [W-1:0] x, input logic signed [W-1:0] y);
		logic [W:0] s;
		sv_t        r;
		s   = {x[W-1], x} - {y[W-1], y};
		r.f = s[W] ^ s[W-1];
		r.v = r.f ? (s[W] ? MINV : MAXV) : s[W-1:0];
		return r;
	endfunction

	function automatic sv_t f_abs(input logic signed [W-1:0] x);
		sv_t r;
		r.f = (x == MINV);
		r.v = r.f ? MAXV : (x[W-1] ? -x : x);
		return r;
	endfunction

	// configuration
	logic signed [W-1:0] fy1_q, k1_q, kp1_q, fy2_q, k2_q, kp2_q;
	logic [W-2:0]        gap_q;

	// committed and trial state
	logic signed [W-1:0] cstrain_q, tstrain_q, cs2u_q, ts2u_q, cstress_q, tstress_q;
	logic signed [W-1:0] cs1_q, ts1_q, cs2f_q, ts2f_q, cslope_q, tslope_q, cgap_q, tgap_q;

	// working registers
	logic [3:0]          state_q;
	logic                issued_q, stage_q, closed_q, pos_q, sat_q;
	logic [1:0]          stat_q;
	logic signed [W-1:0] s_q, d_q, fp_q, up_q, du_q, fn_q, base_q, ratio_q, off_q;
	logic signed [W-1:0] s1_q, t2_q, g_q, s2u_q, cm_q, den_q, stress_q;
	logic                ov_q;
	logic signed [W-1:0] os_q, ot_q;
	logic [1:0]          ost_q;

	// shared unit
	tsg_pkg::md_ctl_t    md_ctl;
	logic signed [W-1:0] md_a, md_b, md_c, md_res;
	logic                md_sat, md_done;

	tsg_md #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_md (
		.clk(clk), .arst_n(arst_n), .ctl(md_ctl), .a(md_a), .b(md_b), .c(md_c),
		.res(md_res), .sat(md_sat), .done(md_done)
	);

	logic signed [W-1:0] fy_sel, k_sel, kp_sel, ua, ua_n;
	sv_t                 upd, one_r, clip_hi, clip_lo, d_in, fn_new, dsf;
	logic signed [W-1:0] clip_f;
	logic                md_state, accept;

	assign fy_sel = stage_q ? fy2_q : fy1_q;
	assign k_sel  = stage_q ? k2_q : k1_q;
	assign kp_sel = stage_q ? kp2_q : kp1_q;
	assign ua     = {1'b0, gap_q};
	assign ua_n   = -ua;
	assign upd    = f_add(up_q, du_q);
	assign one_r  = f_sub(ONE_SAT, ratio_q);
	assign clip_hi = f_add(base_q, off_q);
	assign clip_lo = f_sub(base_q, off_q);
	assign d_in   = f_sub(in_ch.strain, cstrain_q);
	assign fn_new = f_add(fp_q, md_res);
	assign dsf    = f_sub(stress_q, cstress_q);
	assign accept = in_ch.valid && in_ch.ready;
	assign md_state = (state_q == ST_MDK) || (state_q == ST_BASE) || (state_q == ST_RATIO)
		|| (state_q == ST_OFF) || (state_q == ST_SPLIT) || (state_q == ST_SLOPE);

	always_comb begin
		if (du_q > 0 && fn_q > clip_hi.v)
			clip_f = clip_hi.v;
		else if (du_q < 0 && fn_q < clip_lo.v)
			clip_f = clip_lo.v;
		else
			clip_f = fn_q;
	end

	always_comb begin
		md_ctl.start = md_state && !issued_q;
		md_ctl.mode  = tsg_pkg::MD_MUL;
		md_a = du_q;
		md_b = k_sel;
		md_c = k_sel;
		case (state_q)
			ST_BASE: begin
				md_a = kp_sel;
				md_b = upd.v;
			end
			ST_RATIO: begin
				md_ctl.mode = tsg_pkg::MD_DIV;
				md_a = kp_sel;
			end
			ST_OFF: begin
				md_a = one_r.v;
				md_b = fy_sel;
			end
			ST_SPLIT: begin
				md_ctl.mode = tsg_pkg::MD_GEN;
				md_a = d_q;
				md_b = cm_q;
				md_c = den_q;
			end
			ST_SLOPE: begin
				md_ctl.mode = tsg_pkg::MD_DIV;
				md_a = dsf.v;
				md_c = d_q;
			end
			default: ;
		endcase
	end

	// gap bookkeeping for stage two
	sv_t                 g_sum, g_tmp, s2u_new, cm_r, t2_abs, den_r, sp_e, sp_g, sum_r;
	logic signed [W-1:0] ds2, g_new, g_sp;
	logic                g_open, g_edge, g_pos, rev;

	always_comb begin
		g_open = (cgap_q > ua_n) && (cgap_q < ua);
		g_pos  = (cgap_q == ua);
		g_edge = g_pos || (cgap_q == ua_n);
		g_sum  = f_add(cgap_q, d_q);
		if (d_q > 0) begin
			g_tmp = f_sub(g_sum.v, ua);
			ds2   = (g_tmp.v > 0) ? g_tmp.v : '0;
			g_new = (g_sum.v < ua) ? g_sum.v : ua;
		end else begin
			g_tmp = f_add(g_sum.v, ua);
			ds2   = (g_tmp.v < 0) ? g_tmp.v : '0;
			g_new = (g_sum.v > ua_n) ? g_sum.v : ua_n;
		end
		if (!g_open) begin
			ds2   = d_q;
			g_new = cgap_q;
		end
		s2u_new = f_add(cs2u_q, ds2);
		rev     = closed_q && (pos_q ? (d_q <= 0 && t2_q < 0) : (d_q >= 0 && t2_q > 0));
		cm_r    = f_abs(cs2f_q);
		t2_abs  = f_abs(t2_q);
		den_r   = f_add(t2_abs.v, cm_r.v);
		sp_e    = f_sub(d_q, md_res);
		sp_g    = f_add(pos_q ? ua : ua_n, sp_e.v);
		g_sp    = sp_g.v;
		if (pos_q && sp_g.v < ua_n)
			g_sp = ua_n;
		if (!pos_q && sp_g.v > ua)
			g_sp = ua;
		sum_r   = f_add(s1_q, t2_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fy1_q <= '0;
			k1_q  <= ONE_SAT;
			kp1_q <= '0;
			fy2_q <= '0;
			k2_q  <= ONE_SAT;
			kp2_q <= '0;
			gap_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tsg_pkg::REG_FY1: fy1_q <= cfg_data;
				tsg_pkg::REG_K1:  k1_q  <= cfg_data;
				tsg_pkg::REG_KP1: kp1_q <= cfg_data;
				tsg_pkg::REG_FY2: fy2_q <= cfg_data;
				tsg_pkg::REG_K2:  k2_q  <= cfg_data;
				tsg_pkg::REG_KP2: kp2_q <= cfg_data;
				tsg_pkg::REG_GAP: gap_q <= cfg_data[W-2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
			ov_q     <= 1'b0;
			cstrain_q <= '0; tstrain_q <= '0; cs2u_q <= '0; ts2u_q <= '0;
			cstress_q <= '0; tstress_q <= '0; cs1_q <= '0; ts1_q <= '0;
			cs2f_q <= '0; ts2f_q <= '0; cgap_q <= '0; tgap_q <= '0;
			cslope_q <= ONE_SAT;
			tslope_q <= ONE_SAT;
		end else begin
			if (out_ch.ready)
				ov_q <= 1'b0;
			if (md_ctl.start)
				issued_q <= 1'b1;
			if (md_done)
				issued_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						stat_q  <= tsg_pkg::STATUS_OK;
						state_q <= ST_OUT;
						case (in_ch.func)
							tsg_pkg::FUNC_SET: begin
								s_q   <= in_ch.strain;
								d_q   <= d_in.v;
								sat_q <= d_in.f;
								tstrain_q <= in_ch.strain;
								ts2u_q <= cs2u_q; tstress_q <= cstress_q; ts1_q <= cs1_q;
								ts2f_q <= cs2f_q; tslope_q <= cslope_q; tgap_q <= cgap_q;
								stage_q <= 1'b0;
								fp_q <= cs1_q;
								up_q <= cstrain_q;
								du_q <= d_in.v;
								s1_q <= '0;
								if (d_in.v != '0)
									state_q <= (fy1_q == '0) ? ST_GAP : ST_MDK;
							end
							tsg_pkg::FUNC_COMMIT: begin
								cstrain_q <= tstrain_q; cs2u_q <= ts2u_q;
								cstress_q <= tstress_q; cs1_q <= ts1_q; cs2f_q <= ts2f_q;
								cslope_q <= tslope_q; cgap_q <= tgap_q;
							end
							tsg_pkg::FUNC_REVERT: begin
								tstrain_q <= cstrain_q; ts2u_q <= cs2u_q;
								tstress_q <= cstress_q; ts1_q <= cs1_q; ts2f_q <= cs2f_q;
								tslope_q <= cslope_q; tgap_q <= cgap_q;
							end
							default: begin
								cstrain_q <= '0; tstrain_q <= '0; cs2u_q <= '0;
								ts2u_q <= '0; cstress_q <= '0; tstress_q <= '0;
								cs1_q <= '0; ts1_q <= '0; cs2f_q <= '0; ts2f_q <= '0;
								cgap_q <= '0; tgap_q <= '0;
								cslope_q <= k1_q;
								tslope_q <= k1_q;
							end
						endcase
					end
				end
				ST_MDK: if (md_done) begin
					fn_q    <= fn_new.v;
					sat_q   <= sat_q | md_sat | fn_new.f;
					state_q <= ST_BASE;
				end
				ST_BASE: if (md_done) begin
					base_q  <= md_res;
					sat_q   <= sat_q | md_sat | upd.f;
					state_q <= ST_RATIO;
				end
				ST_RATIO: if (md_done) begin
					ratio_q <= md_res;
					sat_q   <= sat_q | md_sat;
					state_q <= ST_OFF;
				end
				ST_OFF: if (md_done) begin
					off_q   <= md_res;
					sat_q   <= sat_q | md_sat | one_r.f;
					state_q <= ST_CLIP;
				end
				ST_CLIP: begin
					sat_q <= sat_q | clip_hi.f | clip_lo.f;
					if (stage_q) begin
						t2_q    <= clip_f;
						state_q <= ST_POST;
					end else begin
						s1_q    <= clip_f;
						state_q <= ST_GAP;
					end
				end
				ST_GAP: begin
					if (g_open || g_edge) begin
						sat_q    <= sat_q | (g_open & (g_sum.f | g_tmp.f)) | s2u_new.f;
						closed_q <= !g_open;
						pos_q    <= g_pos;
						g_q      <= g_new;
						s2u_q    <= s2u_new.v;
						stage_q  <= 1'b1;
						fp_q     <= cs2f_q;
						up_q     <= cs2u_q;
						du_q     <= ds2;
						t2_q     <= '0;
						state_q  <= (fy2_q == '0) ? ST_POST : ST_MDK;
					end else begin
						ts1_q   <= s1_q;
						stat_q  <= tsg_pkg::STATUS_GAP;
						state_q <= ST_OUT;
					end
				end
				ST_POST: begin
					state_q <= ST_SUM;
					if (rev) begin
						sat_q <= sat_q | cm_r.f | t2_abs.f | den_r.f;
						t2_q  <= '0;
						cm_q  <= cm_r.v;
						den_q <= den_r.v;
						if (den_r.v > 0)
							state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: if (md_done) begin
					g_q     <= g_sp;
					sat_q   <= sat_q | md_sat | sp_e.f | sp_g.f;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					stress_q <= sum_r.v;
					sat_q    <= sat_q | sum_r.f;
					state_q  <= ST_SLOPE;
				end
				ST_SLOPE: if (md_done) begin
					tstrain_q <= s_q; ts2u_q <= s2u_q; tstress_q <= stress_q;
					ts1_q <= s1_q; ts2f_q <= t2_q; tslope_q <= md_res; tgap_q <= g_q;
					stat_q <= (sat_q | md_sat | dsf.f)
						? tsg_pkg::STATUS_SAT : tsg_pkg::STATUS_OK;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!ov_q || out_ch.ready) begin
						os_q    <= tstress_q;
						ot_q    <= tslope_q;
						ost_q   <= stat_q;
						ov_q    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ch.ready    = (state_q == ST_IDLE);
	assign out_ch.valid   = ov_q;
	assign out_ch.stress  = os_q;
	assign out_ch.tangent = ot_q;
	assign out_ch.status  = ost_q;

	a_md_owned: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> md_state)
		else $error("shared unit finished outside a sequencer step");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.status == tsg_pkg::STATUS_OK
			|| out_ch.status == tsg_pkg::STATUS_GAP || out_ch.status == tsg_pkg::STATUS_SAT))
		else $error("reserved status code");

	a_to_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_ch.func == tsg_pkg::FUNC_START)
		|=> (tstrain_q == '0 && cstress_q == '0 && tslope_q == cslope_q))
		else $error("revert to start left state behind");

endmodule
